// ----- rtl/sawarq_pkg.sv -----
`timescale 1ns / 1ps

package sawarq_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 14600;
  localparam int unsigned TICK_WIDTH_DEF  = 24;
  localparam int unsigned INIT_TIMEOUT    = 500;
  localparam int unsigned CFG_W           = 24;
  localparam int unsigned LEN_W           = 14;
  localparam int unsigned WORD_W          = 16;

  localparam logic [WORD_W-1:0] FLAG_ACK  = 16'h0002;
  localparam logic [WORD_W-1:0] FLAG_LAST = 16'h0008;
  localparam logic [WORD_W-1:0] FLAG_RST  = 16'h0010;
  localparam logic [WORD_W-1:0] SUM_GOOD  = 16'hffff;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WORD  = 2'd1,
    ACT_RX    = 2'd2,
    ACT_TICK  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    EV_SEND      = 2'd0,
    EV_RESEND    = 2'd1,
    EV_DELIVERED = 2'd2,
    EV_RESET     = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOAD = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  typedef struct packed {
    act_t              action;
    logic [LEN_W-1:0]  seg_length;
    logic              last_segment;
    logic [WORD_W-1:0] payload_word;
    logic              payload_end;
    logic [WORD_W-1:0] rx_seq;
    logic [WORD_W-1:0] rx_ack;
    logic [WORD_W-1:0] rx_flags;
    logic [WORD_W-1:0] rx_sum;
    logic [WORD_W-1:0] rx_len;
  } item_t;

  typedef struct packed {
    ev_t               event_kind;
    logic              tx_seq;
    logic              tx_last;
    logic [WORD_W-1:0] tx_checksum;
    logic [LEN_W-1:0]  tx_length;
  } result_t;

  // 16-bit add with end-around carry
  function automatic logic [WORD_W-1:0] add16(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
  endfunction

endpackage

// ----- rtl/stop_and_wait_arq_sender.sv -----
// Sender half of an alternating-bit stop-and-wait link. A start item opens a
// segment, payload words fold into a ones' complement checksum, and the last
// word (or a zero-length start) produces the transmit header item; ticks
// then time the wait, a timeout produces a retransmit item, and a good
// received header with a matching ACK (delivered) or RST (reset) closes the
// segment and flips the sequence bit. Every item is taken into an input
// register, handled there by the segment logic, and any result lands in an
// output register, so one item is accepted per clock while in_stall is low.
// The segment logic on the input register sets the cycle time: the
// end-around checksum adds, the timeout compare and the reciprocal multiply
// that divides four times the estimate plus the ticks since the first send
// by five. While a result waits on out_stall, one more item can be held in
// the input register before in_stall rises. Writing cfg_initial_timeout
// reloads the round-trip estimate; write it only while the block is idle.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender #(
  parameter int unsigned MAX_PAYLOAD = sawarq_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned TICK_WIDTH  = sawarq_pkg::TICK_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [13:0] in_seg_length,
  input  logic        in_last_segment,
  input  logic [15:0] in_payload_word,
  input  logic        in_payload_end,
  input  logic [15:0] in_rx_seq,
  input  logic [15:0] in_rx_ack,
  input  logic [15:0] in_rx_flags,
  input  logic [15:0] in_rx_sum,
  input  logic [15:0] in_rx_len,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic        out_tx_seq,
  output logic        out_tx_last,
  output logic [15:0] out_tx_checksum,
  output logic [13:0] out_tx_length,

  input  logic        cfg_we,
  input  logic [23:0] cfg_initial_timeout
);

  sawarq_pkg::item_t   in_item;
  sawarq_pkg::item_t   item;
  logic                item_valid;
  logic                take;
  logic                can_load;
  logic                res_valid;
  sawarq_pkg::result_t res;
  sawarq_pkg::result_t out_res;

  // pack the input ports into one item
  assign in_item.action       = sawarq_pkg::act_t'(in_action);
  assign in_item.seg_length   = in_seg_length;
  assign in_item.last_segment = in_last_segment;
  assign in_item.payload_word = in_payload_word;
  assign in_item.payload_end  = in_payload_end;
  assign in_item.rx_seq       = in_rx_seq;
  assign in_item.rx_ack       = in_rx_ack;
  assign in_item.rx_flags     = in_rx_flags;
  assign in_item.rx_sum       = in_rx_sum;
  assign in_item.rx_len       = in_rx_len;

  sawarq_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // segment state machine, checksum, timer and estimate
  sawarq_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .can_load   (can_load),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_initial_timeout)
  );

  // result register; frees up in the same cycle its item is taken
  sawarq_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid & take),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_kind  = out_res.event_kind;
  assign out_tx_seq      = out_res.tx_seq;
  assign out_tx_last     = out_res.tx_last;
  assign out_tx_checksum = out_res.tx_checksum;
  assign out_tx_length   = out_res.tx_length;

endmodule

// ----- rtl/sawarq_in_reg.sv -----
`timescale 1ns / 1ps

module sawarq_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sawarq_pkg::item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output sawarq_pkg::item_t item
);

  logic              vld_r, vld_nxt;
  sawarq_pkg::item_t item_r;
  logic              load;

  assign in_stall = vld_r & ~take;
  assign load     = in_valid & ~in_stall;
  assign vld_nxt  = load | (vld_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

// ----- rtl/sawarq_out_reg.sv -----
`timescale 1ns / 1ps

module sawarq_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sawarq_pkg::result_t res,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output sawarq_pkg::result_t out_res
);

  logic                vld_r, vld_nxt;
  sawarq_pkg::result_t res_r;

  assign can_load = ~vld_r | ~out_stall;
  assign vld_nxt  = load | (vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/sawarq_core.sv -----
`timescale 1ns / 1ps

module sawarq_core #(
  parameter int unsigned MAX_PAYLOAD = sawarq_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned TICK_WIDTH  = sawarq_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  input  sawarq_pkg::item_t              item,
  input  logic                           can_load,
  output logic                           take,
  output logic                           res_valid,
  output sawarq_pkg::result_t            res,
  input  logic                           cfg_we,
  input  logic [sawarq_pkg::CFG_W-1:0]   cfg_data
);

  localparam int unsigned TW = TICK_WIDTH;
  localparam int unsigned LW = sawarq_pkg::LEN_W;
  localparam int unsigned WW = sawarq_pkg::WORD_W;
  // width of 4*est + since_first and of the 5x / 6x compare terms
  localparam int unsigned XW = TW + 3;
  localparam logic [XW-1:0] DIV5_MUL = XW'((64'd1 << XW) / 64'd5);
  localparam logic [WW-1:0] MAX_LEN  = WW'(MAX_PAYLOAD);
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  sawarq_pkg::phase_t phase_r, phase_nxt;
  logic               seq_r, seq_nxt;
  logic [WW-1:0]      sum_r, sum_nxt;
  logic [WW-1:0]      chk_r, chk_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic               last_r, last_nxt;
  logic [TW-1:0]      since_send_r, since_send_nxt;
  logic [TW-1:0]      since_first_r, since_first_nxt;
  logic [TW-1:0]      est_r, est_nxt;
  logic               resent_r, resent_nxt;

  logic               emit;
  sawarq_pkg::ev_t    kind;

  // start: clamp and header sum (the zero ack and checksum words add nothing)
  logic [LW-1:0]      len_clamp;
  logic [WW-1:0]      hdr_sum;
  logic [WW-1:0]      word_sum;

  // received header check
  logic [WW+2:0]      rx_total;
  logic [WW:0]        rx_fold;
  logic [WW-1:0]      rx_ones;
  logic               rx_good, ack_hit, rst_hit;

  // ticks and timeout
  logic [TW-1:0]      ss_inc, sf_inc;
  logic [XW-1:0]      ss_x5, est_x6;
  logic               timeout;

  // estimate update: floor((4*est + since_first) / 5)
  logic [XW-1:0]      div_x;
  logic [2*XW-1:0]    div_prod;
  logic [XW-1:0]      div_q0, div_r, div_q;
  logic [TW-1:0]      est_upd;

  assign take = item_valid & can_load;

  assign len_clamp = ({{(WW-LW){1'b0}}, item.seg_length} > MAX_LEN) ? LW'(MAX_PAYLOAD)
                                                                    : item.seg_length;
  assign hdr_sum  = sawarq_pkg::add16(
                      sawarq_pkg::add16({{(WW-1){1'b0}}, seq_r},
                                        item.last_segment ? sawarq_pkg::FLAG_LAST : '0),
                      {{(WW-LW){1'b0}}, len_clamp});
  assign word_sum = sawarq_pkg::add16(sum_r, item.payload_word);

  assign rx_total = {3'b000, item.rx_seq} + {3'b000, item.rx_ack} + {3'b000, item.rx_flags}
                  + {3'b000, item.rx_sum} + {3'b000, item.rx_len};
  assign rx_fold  = {1'b0, rx_total[WW-1:0]} + {{(WW-2){1'b0}}, rx_total[WW+2:WW]};
  assign rx_ones  = rx_fold[WW-1:0] + {{(WW-1){1'b0}}, rx_fold[WW]};
  assign rx_good  = (rx_ones == sawarq_pkg::SUM_GOOD);
  assign ack_hit  = rx_good && ((item.rx_flags & sawarq_pkg::FLAG_ACK) != '0)
                    && (item.rx_ack == {{(WW-1){1'b0}}, seq_r});
  assign rst_hit  = rx_good && ((item.rx_flags & sawarq_pkg::FLAG_RST) != '0);

  assign ss_inc  = (since_send_r == TICK_MAX) ? since_send_r : since_send_r + 1'b1;
  assign sf_inc  = (since_first_r == TICK_MAX) ? since_first_r : since_first_r + 1'b1;
  assign ss_x5   = {1'b0, ss_inc, 2'b00} + {3'b000, ss_inc};
  assign est_x6  = {1'b0, est_r, 2'b00} + {2'b00, est_r, 1'b0};
  assign timeout = ss_x5 > est_x6;

  // reciprocal multiply lands on q or q-1; one compare fixes it
  assign div_x    = {1'b0, est_r, 2'b00} + {3'b000, since_first_r};
  assign div_prod = div_x * DIV5_MUL;
  assign div_q0   = div_prod[2*XW-1:XW];
  assign div_r    = div_x - ({div_q0[XW-3:0], 2'b00} + div_q0);
  assign div_q    = (div_r >= XW'(5)) ? div_q0 + 1'b1 : div_q0;
  assign est_upd  = div_q[TW-1:0];

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (item.action)
        sawarq_pkg::ACT_START: begin
          if (phase_r == sawarq_pkg::PH_IDLE) begin
            phase_nxt = (len_clamp == '0) ? sawarq_pkg::PH_WAIT : sawarq_pkg::PH_LOAD;
          end
        end
        sawarq_pkg::ACT_WORD: begin
          if (phase_r == sawarq_pkg::PH_LOAD && item.payload_end) begin
            phase_nxt = sawarq_pkg::PH_WAIT;
          end
        end
        sawarq_pkg::ACT_RX: begin
          if (phase_r == sawarq_pkg::PH_WAIT && (ack_hit || rst_hit)) begin
            phase_nxt = sawarq_pkg::PH_IDLE;
          end
        end
        sawarq_pkg::ACT_TICK: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // segment state and results
  always_comb begin
    seq_nxt         = seq_r;
    sum_nxt         = sum_r;
    chk_nxt         = chk_r;
    len_nxt         = len_r;
    last_nxt        = last_r;
    since_send_nxt  = since_send_r;
    since_first_nxt = since_first_r;
    est_nxt         = est_r;
    resent_nxt      = resent_r;
    emit            = 1'b0;
    kind            = sawarq_pkg::EV_SEND;

    if (take) begin
      unique case (item.action)
        sawarq_pkg::ACT_START: begin
          if (phase_r == sawarq_pkg::PH_IDLE) begin
            len_nxt  = len_clamp;
            last_nxt = item.last_segment;
            sum_nxt  = hdr_sum;
            if (len_clamp == '0) begin
              chk_nxt         = ~hdr_sum;
              since_send_nxt  = '0;
              since_first_nxt = '0;
              resent_nxt      = 1'b0;
              emit            = 1'b1;
              kind            = sawarq_pkg::EV_SEND;
            end
          end
        end
        sawarq_pkg::ACT_WORD: begin
          if (phase_r == sawarq_pkg::PH_LOAD) begin
            sum_nxt = word_sum;
            if (item.payload_end) begin
              chk_nxt         = ~word_sum;
              since_send_nxt  = '0;
              since_first_nxt = '0;
              resent_nxt      = 1'b0;
              emit            = 1'b1;
              kind            = sawarq_pkg::EV_SEND;
            end
          end
        end
        sawarq_pkg::ACT_RX: begin
          if (phase_r == sawarq_pkg::PH_WAIT) begin
            if (ack_hit) begin
              if (!resent_r) begin
                est_nxt = est_upd;
              end
              seq_nxt = ~seq_r;
              emit    = 1'b1;
              kind    = sawarq_pkg::EV_DELIVERED;
            end else if (rst_hit) begin
              seq_nxt = ~seq_r;
              emit    = 1'b1;
              kind    = sawarq_pkg::EV_RESET;
            end
          end
        end
        sawarq_pkg::ACT_TICK: begin
          if (phase_r == sawarq_pkg::PH_WAIT) begin
            since_send_nxt  = ss_inc;
            since_first_nxt = sf_inc;
            if (timeout) begin
              since_send_nxt = '0;
              resent_nxt     = 1'b1;
              emit           = 1'b1;
              kind           = sawarq_pkg::EV_RESEND;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    if (cfg_we) begin
      est_nxt = TW'(cfg_data);
    end
  end

  assign res_valid       = emit;
  assign res.event_kind  = kind;
  assign res.tx_seq      = seq_r;
  assign res.tx_last     = last_nxt;
  assign res.tx_checksum = chk_nxt;
  assign res.tx_length   = len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= sawarq_pkg::PH_IDLE;
      seq_r         <= 1'b0;
      sum_r         <= '0;
      chk_r         <= '0;
      len_r         <= '0;
      last_r        <= 1'b0;
      since_send_r  <= '0;
      since_first_r <= '0;
      est_r         <= TW'(sawarq_pkg::INIT_TIMEOUT);
      resent_r      <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      seq_r         <= seq_nxt;
      sum_r         <= sum_nxt;
      chk_r         <= chk_nxt;
      len_r         <= len_nxt;
      last_r        <= last_nxt;
      since_send_r  <= since_send_nxt;
      since_first_r <= since_first_nxt;
      est_r         <= est_nxt;
      resent_r      <= resent_nxt;
    end
  end

endmodule

// ----- rtl/sawarq_chk.sv -----
`timescale 1ns / 1ps

module sawarq_chk #(
  parameter int unsigned MAX_PAYLOAD = sawarq_pkg::MAX_PAYLOAD_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_kind,
  input logic        out_tx_seq,
  input logic        out_tx_last,
  input logic [15:0] out_tx_checksum,
  input logic [13:0] out_tx_length
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) && $stable(out_tx_seq)
      && $stable(out_tx_last) && $stable(out_tx_checksum) && $stable(out_tx_length))
    else $error("stalled result changed");

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("registers not empty after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // reported length is always clamped
  a_len_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {2'b00, out_tx_length} <= MAX_LEN)
    else $error("segment length above limit");

endmodule

bind stop_and_wait_arq_sender sawarq_chk #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_sawarq_chk (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam longint unsigned TICK_MAX = (64'd1 << sawarq_pkg::TICK_WIDTH_DEF) - 64'd1;
  // Settling time before a register write: input reg + output reg, with slack
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIVE_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES = 6;
  localparam logic [23:0] PHASE_TIMEOUT [NUM_PHASES] =
    '{24'd16777215, 24'd500, 24'd1, 24'd40, 24'd9000, 24'd3};

  typedef struct {
    bit                  is_cfg;
    logic [23:0]         cfg_val;
    sawarq_pkg::item_t   it;
    bit                  fixed;
    sawarq_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_kind;
  logic        out_tx_seq;
  logic        out_tx_last;
  logic [15:0] out_tx_checksum;
  logic [13:0] out_tx_length;
  logic        cfg_we;
  logic [23:0] cfg_initial_timeout;

  // Item on offer, plus the hand-written expectation that rides with it
  sawarq_pkg::item_t   drv_item;
  bit                  drv_fixed;
  sawarq_pkg::result_t drv_want;

  // Segment predictor state
  logic                seg_seq;
  sawarq_pkg::phase_t  seg_phase;
  logic [15:0]         fold_sum;
  logic [15:0]         hold_sum;
  logic [13:0]         hold_len;
  logic                hold_last;
  longint unsigned     ticks_send;
  longint unsigned     ticks_first;
  longint unsigned     rtt_est;
  bit                  resent;

  sawarq_pkg::result_t expected_events[$];
  stim_row_t           directed_rows[$];
  int unsigned         errors;
  int unsigned         live_cnt;

  // Stimulus shaping
  int unsigned send_gap_pct;
  int unsigned rx_stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  int          words_left;
  bit          pad_tail;

  logic [1:0]  in_action_w;
  logic [13:0] in_seg_length_w;
  assign {in_action_w, in_seg_length_w} = {drv_item.action, drv_item.seg_length};

  stop_and_wait_arq_sender i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action_w),
    .in_seg_length       (in_seg_length_w),
    .in_last_segment     (drv_item.last_segment),
    .in_payload_word     (drv_item.payload_word),
    .in_payload_end      (drv_item.payload_end),
    .in_rx_seq           (drv_item.rx_seq),
    .in_rx_ack           (drv_item.rx_ack),
    .in_rx_flags         (drv_item.rx_flags),
    .in_rx_sum           (drv_item.rx_sum),
    .in_rx_len           (drv_item.rx_len),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_kind      (out_event_kind),
    .out_tx_seq          (out_tx_seq),
    .out_tx_last         (out_tx_last),
    .out_tx_checksum     (out_tx_checksum),
    .out_tx_length       (out_tx_length),
    .cfg_we              (cfg_we),
    .cfg_initial_timeout (cfg_initial_timeout)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Ones' complement add: wrap the carry back into bit 0.
  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    int unsigned t;
    t = int'(a) + int'(b);
    if (t > 32'h0000_ffff) t -= 32'h0000_ffff;
    return t[15:0];
  endfunction

  // Every event reports the current segment, seq bit taken before any flip.
  function automatic sawarq_pkg::result_t seg_event(sawarq_pkg::ev_t k);
    return {k, seg_seq, hold_last, hold_sum, hold_len};
  endfunction

  // Last payload word (or zero length): latch checksum and start the wait.
  function automatic sawarq_pkg::result_t close_load();
    hold_sum = ~fold_sum;
    seg_phase = sawarq_pkg::PH_WAIT;
    ticks_send = 0;
    ticks_first = 0;
    resent = 1'b0;
    return seg_event(sawarq_pkg::EV_SEND);
  endfunction

  function automatic void model_reset();
    seg_seq = 1'b0;
    seg_phase = sawarq_pkg::PH_IDLE;
    fold_sum = '0;
    hold_sum = '0;
    hold_len = '0;
    hold_last = 1'b0;
    ticks_send = 0;
    ticks_first = 0;
    rtt_est = sawarq_pkg::INIT_TIMEOUT;
    resent = 1'b0;
  endfunction

  // live: the item was taken in the current phase rather than dropped.
  function automatic void predict_segment_event(input sawarq_pkg::item_t it,
                                                output bit fired, output bit live,
                                                output sawarq_pkg::result_t res);
    logic [15:0] rx_fold;
    bit          good;
    fired = 1'b0;
    live = 1'b0;
    res = '0;
    case (it.action)
      sawarq_pkg::ACT_START: begin
        if (seg_phase == sawarq_pkg::PH_IDLE) begin
          live = 1'b1;
          if (it.seg_length > 14'(sawarq_pkg::MAX_PAYLOAD_DEF))
            hold_len = 14'(sawarq_pkg::MAX_PAYLOAD_DEF);
          else hold_len = it.seg_length;
          hold_last = it.last_segment;
          // header words: seq, ack (0), flags, checksum slot (0), length
          fold_sum = ones_add(16'h0000, {15'b0, seg_seq});
          fold_sum = ones_add(fold_sum, 16'h0000);
          fold_sum = ones_add(fold_sum, hold_last ? sawarq_pkg::FLAG_LAST : 16'h0000);
          fold_sum = ones_add(fold_sum, 16'h0000);
          fold_sum = ones_add(fold_sum, {2'b00, hold_len});
          if (hold_len == 14'd0) begin
            res = close_load();
            fired = 1'b1;
          end else begin
            seg_phase = sawarq_pkg::PH_LOAD;
          end
        end
      end
      sawarq_pkg::ACT_WORD: begin
        if (seg_phase == sawarq_pkg::PH_LOAD) begin
          live = 1'b1;
          fold_sum = ones_add(fold_sum, it.payload_word);
          if (it.payload_end) begin
            res = close_load();
            fired = 1'b1;
          end
        end
      end
      sawarq_pkg::ACT_RX: begin
        if (seg_phase == sawarq_pkg::PH_WAIT) begin
          live = 1'b1;
          rx_fold = ones_add(16'h0000, it.rx_seq);
          rx_fold = ones_add(rx_fold, it.rx_ack);
          rx_fold = ones_add(rx_fold, it.rx_flags);
          rx_fold = ones_add(rx_fold, it.rx_sum);
          rx_fold = ones_add(rx_fold, it.rx_len);
          good = (rx_fold == sawarq_pkg::SUM_GOOD);
          // matching ACK wins over RST when both flags are set
          if (good && (it.rx_flags & sawarq_pkg::FLAG_ACK) != 0
              && it.rx_ack == {15'b0, seg_seq}) begin
            if (!resent) rtt_est = ((4 * rtt_est + ticks_first) / 5) & TICK_MAX;
            res = seg_event(sawarq_pkg::EV_DELIVERED);
            fired = 1'b1;
          end else if (good && (it.rx_flags & sawarq_pkg::FLAG_RST) != 0) begin
            res = seg_event(sawarq_pkg::EV_RESET);
            fired = 1'b1;
          end
          if (fired) begin
            seg_seq = ~seg_seq;
            seg_phase = sawarq_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        if (seg_phase == sawarq_pkg::PH_WAIT) begin
          live = 1'b1;
          if (ticks_send < TICK_MAX) ticks_send++;
          if (ticks_first < TICK_MAX) ticks_first++;
          // timeout at elapsed > 1.2 * estimate, kept in integers
          if (ticks_send * 5 > rtt_est * 6) begin
            ticks_send = 0;
            resent = 1'b1;
            res = seg_event(sawarq_pkg::EV_RESEND);
            fired = 1'b1;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: inputs and outputs both sampled at the rising edge
  // ---------------------------------------------------------------------

  function automatic void field_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
  endfunction

  always @(posedge clk) begin : scoreboard
    bit                  fired;
    bit                  live;
    sawarq_pkg::result_t pred;
    sawarq_pkg::result_t got;
    sawarq_pkg::result_t want;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        predict_segment_event(drv_item, fired, live, pred);
        if (live) live_cnt++;
        if (drv_fixed) expected_events.push_back(drv_want);
        else if (fired) expected_events.push_back(pred);
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got = {out_event_kind, out_tx_seq, out_tx_last, out_tx_checksum, out_tx_length};
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: result item with nothing expected, kind %0h checksum %0h",
                   $time, got.event_kind, got.tx_checksum);
        end else begin
          want = expected_events.pop_front();
          if (got.event_kind !== want.event_kind)
            field_diff("event_kind", want.event_kind, got.event_kind);
          if (got.tx_seq !== want.tx_seq)
            field_diff("tx_seq", want.tx_seq, got.tx_seq);
          if (got.tx_last !== want.tx_last)
            field_diff("tx_last", want.tx_last, got.tx_last);
          if (got.tx_checksum !== want.tx_checksum)
            field_diff("tx_checksum", want.tx_checksum, got.tx_checksum);
          if (got.tx_length !== want.tx_length)
            field_diff("tx_length", want.tx_length, got.tx_length);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // ---------------------------------------------------------------------

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 80;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic sawarq_pkg::item_t start_item(logic [13:0] len, logic last);
    sawarq_pkg::item_t it;
    it = '0;
    it.action = sawarq_pkg::ACT_START;
    it.seg_length = len;
    it.last_segment = last;
    return it;
  endfunction

  function automatic sawarq_pkg::item_t word_item(logic [15:0] w, logic endw);
    sawarq_pkg::item_t it;
    it = '0;
    it.action = sawarq_pkg::ACT_WORD;
    it.payload_word = w;
    it.payload_end = endw;
    return it;
  endfunction

  function automatic sawarq_pkg::item_t rx_item(logic [15:0] s, logic [15:0] a,
                                                logic [15:0] f, logic [15:0] c,
                                                logic [15:0] l);
    sawarq_pkg::item_t it;
    it = '0;
    it.action = sawarq_pkg::ACT_RX;
    it.rx_seq = s;
    it.rx_ack = a;
    it.rx_flags = f;
    it.rx_sum = c;
    it.rx_len = l;
    return it;
  endfunction

  function automatic sawarq_pkg::item_t tick_item();
    sawarq_pkg::item_t it;
    it = '0;
    it.action = sawarq_pkg::ACT_TICK;
    return it;
  endfunction

  function automatic void add_row(sawarq_pkg::item_t it, bit fixed = 1'b0,
                                  sawarq_pkg::result_t want = '0);
    directed_rows.push_back('{1'b0, 24'd0, it, fixed, want});
  endfunction

  // Random item shaped by the predicted phase: mostly well-formed segments
  // (start, the right number of words, ticks, a valid answer), some noise.
  function automatic sawarq_pkg::item_t next_item();
    sawarq_pkg::item_t it;
    logic [15:0]       part;
    int unsigned       roll;
    int unsigned       pick;
    it.action = sawarq_pkg::ACT_TICK;
    it.seg_length = 14'($urandom);
    it.last_segment = 1'($urandom);
    it.payload_word = 16'($urandom);
    it.payload_end = 1'($urandom);
    it.rx_seq = 16'($urandom);
    it.rx_ack = 16'($urandom);
    it.rx_flags = 16'($urandom);
    it.rx_sum = 16'($urandom);
    it.rx_len = 16'($urandom);
    roll = $urandom_range(99);
    case (seg_phase)
      sawarq_pkg::PH_IDLE: begin
        if (roll < 88) begin
          it.action = sawarq_pkg::ACT_START;
          pick = $urandom_range(99);
          if (pick < 8) begin
            // any length up to the field max; cut short after a few words
            words_left = $urandom_range(6, 1);
            pad_tail = 1'b0;
          end else begin
            it.seg_length = 14'($urandom_range(40));
            words_left = (it.seg_length + 1) / 2;
            pad_tail = it.seg_length[0];
          end
        end else begin
          it.action = sawarq_pkg::act_t'($urandom_range(3, 1));
        end
      end
      sawarq_pkg::PH_LOAD: begin
        if (roll < 92) begin
          it.action = sawarq_pkg::ACT_WORD;
          it.payload_end = (words_left <= 1);
          if (it.payload_end && pad_tail) it.payload_word[15:8] = 8'h00;
          words_left--;
        end else begin
          it.action = sawarq_pkg::act_t'($urandom_range(3));
        end
      end
      default: begin
        if (roll >= 55) begin
          it.action = sawarq_pkg::ACT_RX;
          if (roll < 85) begin
            if ($urandom_range(99) < 70) begin
              it.rx_flags |= sawarq_pkg::FLAG_ACK;
              it.rx_ack = {15'b0, seg_seq};
            end else begin
              it.rx_flags |= sawarq_pkg::FLAG_RST;
            end
          end else if (roll < 92) begin
            it.rx_flags &= ~(sawarq_pkg::FLAG_ACK | sawarq_pkg::FLAG_RST);
          end
          if (roll < 92) begin
            part = ones_add(ones_add(it.rx_seq, it.rx_ack), it.rx_flags);
            part = ones_add(part, it.rx_len);
            it.rx_sum = ~part;
          end
          // otherwise all words random: checksum nearly always bad
        end
      end
    endcase
    return it;
  endfunction

  // Offer one item at the falling edge and hold it until it is taken.
  task automatic drive(sawarq_pkg::item_t it, bit fixed, sawarq_pkg::result_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv_item <= it;
    drv_fixed <= fixed;
    drv_want <= want;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Stop offering, let every expected result out, then let the pipe empty.
  task automatic settle();
    int unsigned n;
    in_valid <= 1'b0;
    for (n = 0; n < 20000 && expected_events.size() != 0; n++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Only called once settled; the estimate reloads along with the register.
  task automatic write_timeout(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_initial_timeout <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    rtt_est = v;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    int unsigned p;
    int unsigned base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv_item = '0;
    drv_fixed = 1'b0;
    drv_want = '0;
    cfg_we = 1'b0;
    cfg_initial_timeout = 24'd500;
    send_gap_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    errors = 0;
    live_cnt = 0;
    words_left = 0;
    pad_tail = 1'b0;
    model_reset();

    // Directed rows. Typed expectations are the ones plain from the rules.
    // Zero length straight after reset: header goes out at once.
    add_row(start_item(14'd0, 1'b0), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_SEND, 1'b0, 1'b0, 16'hffff, 14'd0});
    add_row(rx_item(16'h0000, 16'h0000, sawarq_pkg::FLAG_ACK, 16'hfffd, 16'h0000), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_DELIVERED, 1'b0, 1'b0, 16'hffff, 14'd0});
    // idle: tick, word and answer all dropped
    add_row(tick_item());
    add_row(word_item(16'hffff, 1'b1));
    add_row(rx_item(16'h0000, 16'h0001, sawarq_pkg::FLAG_ACK, 16'hfffc, 16'h0000));
    directed_rows.push_back('{1'b1, 24'd1, '0, 1'b0, '0});
    // oversized length clamps; restart and tick while loading are dropped
    add_row(start_item(14'h3fff, 1'b1));
    add_row(start_item(14'd5, 1'b0));
    add_row(tick_item());
    add_row(word_item(16'hffff, 1'b0));
    add_row(word_item(16'h0000, 1'b1), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_SEND, 1'b1, 1'b1, 16'hc6ee, 14'd14600});
    // waiting: stray word, bad checksum, no flags, ACK for the other seq
    add_row(word_item(16'h1234, 1'b1));
    add_row(rx_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_row(rx_item(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000));
    add_row(rx_item(16'h0000, 16'h0000, sawarq_pkg::FLAG_ACK, 16'hfffd, 16'h0000));
    // estimate 1: second tick times out
    add_row(tick_item());
    add_row(tick_item(), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_RESEND, 1'b1, 1'b1, 16'hc6ee, 14'd14600});
    add_row(tick_item());
    // ACK and RST together: the matching ACK wins
    add_row(rx_item(16'h0000, 16'h0001, sawarq_pkg::FLAG_ACK | sawarq_pkg::FLAG_RST,
                    16'hffec, 16'h0000), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_DELIVERED, 1'b1, 1'b1, 16'hc6ee,
                                  14'd14600});
    // one odd byte, then a reset answer
    add_row(start_item(14'd1, 1'b0));
    add_row(word_item(16'h00ab, 1'b1), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_SEND, 1'b0, 1'b0, 16'hff53, 14'd1});
    add_row(rx_item(16'h0000, 16'h0001, sawarq_pkg::FLAG_RST, 16'hffee, 16'h0000), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_RESET, 1'b0, 1'b0, 16'hff53, 14'd1});
    // delivery with no ticks drives the estimate to zero
    add_row(start_item(14'd0, 1'b1), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_SEND, 1'b1, 1'b1, 16'hfff6, 14'd0});
    add_row(rx_item(16'h0000, 16'h0001, sawarq_pkg::FLAG_ACK, 16'hfffc, 16'h0000), 1'b1,
            sawarq_pkg::result_t'{sawarq_pkg::EV_DELIVERED, 1'b1, 1'b1, 16'hfff6, 14'd0});
    // zero estimate: first tick already times out
    add_row(start_item(14'd0, 1'b0));
    add_row(tick_item());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_timeout(directed_rows[i].cfg_val);
      end else begin
        drive(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // Random phases: new timeout each time, cycling through the idle mixes
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_timeout(PHASE_TIMEOUT[p]);
      case (p % 4)
        0: begin send_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_gap_pct = 70; rx_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  rx_stall_pct = 70; end
        default: begin send_gap_pct = 23; rx_stall_pct = 23; end
      endcase
      // sender at full rate against a long receiver hold: block must back up
      if (p == 0) hold_req = 1'b1;
      base = live_cnt;
      while (live_cnt - base < LIVE_PER_PHASE) drive(next_item(), 1'b0, '0);
    end

    settle();
    if (expected_events.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time,
               expected_events.size());
      errors += expected_events.size();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
